// ----- sv/khtbl_pkg.sv -----
// Shared types and constants for the keyed handle table.
`timescale 1ns / 1ps

package khtbl_pkg;

   localparam int ENTRIES  = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int COUNT_W  = $clog2(ENTRIES + 1);
   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 31;
   localparam int OP_W     = 2;
   localparam int STAT_W   = 2;
   localparam int USED_W   = 5;

   localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_HANDLE,
      WR_FILL,
      WR_FREE
   } wr_kind_type;

   // Request token walking down the cell row, collecting search results.
   typedef struct packed {
      logic                vld;
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key_high;
      logic [KEY_W-1:0]    key_low;
      logic [HANDLE_W-1:0] handle;
      logic                match_hit;
      logic [IDX_W-1:0]    match_idx;
      logic [HANDLE_W-1:0] match_handle;
      logic                free_hit;
      logic [IDX_W-1:0]    free_idx;
   } tok_type;

   // Update broadcast to every cell once a search has finished.
   typedef struct packed {
      wr_kind_type         kind;
      logic [IDX_W-1:0]    idx;
      logic [KEY_W-1:0]    key_high;
      logic [KEY_W-1:0]    key_low;
      logic [HANDLE_W-1:0] handle;
   } wr_type;

endpackage

// ----- sv/keyed_handle_table.sv -----
// Top level of the keyed handle table: cell row, sequencer and result register.
`timescale 1ns / 1ps
// An accepted item's token is registered in each of the ENTRIES slot cells in turn,
// then in the tail register; then the update commits and the result register loads.
// A new item is taken only once the previous update has committed.
// A result held by a stalled consumer delays the commit of the next item, not its search.
// Reset (synchronous, active high) frees every slot, zeroes the count and
// empties the token row and the result register.

module keyed_handle_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] op, [65:2] key_high, [129:66] key_low, [160:130] handle_in, [167:161] zero
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [32:2] handle_out, [37:33] entries_used, [39:38] zero
   output logic [39:0]  rsp_tdata
);

   localparam int N = khtbl_pkg::ENTRIES;

   khtbl_pkg::state_type state_ff, state_in;
   khtbl_pkg::tok_type   tok [N+1];
   khtbl_pkg::tok_type   tail_ff, tail_in;
   khtbl_pkg::wr_type    wr;

   logic [khtbl_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [khtbl_pkg::STAT_W-1:0]   status_ff, status_in;
   logic [khtbl_pkg::HANDLE_W-1:0] handle_out_ff, handle_out_in;
   logic [khtbl_pkg::USED_W-1:0]   used_ff, used_in;
   logic [khtbl_pkg::USED_W+khtbl_pkg::COUNT_W-1:0] count_ext;
   logic                           accept;
   logic                           out_free;

   // Take a new item only while no search is in flight.
   assign req_tready = (state_ff == khtbl_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Inject the item as a fresh token at the head of the row.
   always_comb begin
      tok[0]              = '0;
      tok[0].vld          = accept;
      tok[0].op           = req_tdata[1:0];
      tok[0].key_high     = req_tdata[65:2];
      tok[0].key_low      = req_tdata[129:66];
      tok[0].handle       = req_tdata[160:130];
   end

   // Row of slot cells; cell 0 is the lowest slot and is searched first.
   for (genvar i = 0; i < N; i++) begin : g_cell
      khtbl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (khtbl_pkg::IDX_W'(i)),
         .tok_in   (tok[i]),
         .wr       (wr),
         .tok_out  (tok[i+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      status_in     = status_ff;
      handle_out_in = handle_out_ff;
      wr            = '0;
      wr.kind       = khtbl_pkg::WR_NONE;
      wr.key_high   = tail_ff.key_high;
      wr.key_low    = tail_ff.key_low;
      wr.handle     = tail_ff.handle;

      case (state_ff)
         khtbl_pkg::S_IDLE: begin
            if (accept) begin
               state_in = khtbl_pkg::S_SCAN;
            end
         end
         khtbl_pkg::S_SCAN: begin
            // hold the finished token when it drops off the end of the row
            if (tok[N].vld) begin
               tail_in  = tok[N];
               state_in = khtbl_pkg::S_DONE;
            end
         end
         khtbl_pkg::S_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               status_in     = khtbl_pkg::STAT_NOT_FOUND;
               handle_out_in = '0;
               state_in      = khtbl_pkg::S_IDLE;
               case (tail_ff.op)
                  khtbl_pkg::OP_REGISTER: begin
                     if (tail_ff.match_hit) begin
                        // overwrite the handle of an existing key
                        wr.kind   = khtbl_pkg::WR_HANDLE;
                        wr.idx    = tail_ff.match_idx;
                        status_in = khtbl_pkg::STAT_OK;
                     end else if (tail_ff.free_hit) begin
                        wr.kind   = khtbl_pkg::WR_FILL;
                        wr.idx    = tail_ff.free_idx;
                        count_in  = count_ff + khtbl_pkg::COUNT_W'(1);
                        status_in = khtbl_pkg::STAT_OK;
                     end else begin
                        status_in = khtbl_pkg::STAT_FULL;
                     end
                  end
                  khtbl_pkg::OP_UNREGISTER: begin
                     if (tail_ff.match_hit) begin
                        wr.kind   = khtbl_pkg::WR_FREE;
                        wr.idx    = tail_ff.match_idx;
                        count_in  = count_ff - khtbl_pkg::COUNT_W'(1);
                        status_in = khtbl_pkg::STAT_OK;
                     end
                  end
                  khtbl_pkg::OP_LOOKUP: begin
                     if (tail_ff.match_hit) begin
                        handle_out_in = tail_ff.match_handle;
                        status_in     = khtbl_pkg::STAT_OK;
                     end
                  end
                  default: begin
                     status_in = khtbl_pkg::STAT_NOT_FOUND;
                  end
               endcase
            end
         end
         default: begin
            state_in = khtbl_pkg::S_IDLE;
         end
      endcase
   end

   // Report the low bits of the count after this item.
   assign count_ext = {{khtbl_pkg::USED_W{1'b0}}, count_in};
   always_comb begin
      used_in = used_ff;
      if ((state_ff == khtbl_pkg::S_DONE) && out_free) begin
         used_in = count_ext[khtbl_pkg::USED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= khtbl_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff       <= tail_in;
      status_ff     <= status_in;
      handle_out_ff <= handle_out_in;
      used_ff       <= used_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, used_ff, handle_out_ff, status_ff};

endmodule

// ----- sv/khtbl_cell.sv -----
// One table slot: holds a key and handle, checks a passing token against them.
`timescale 1ns / 1ps

module khtbl_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [khtbl_pkg::IDX_W-1:0] cell_idx,
   input  khtbl_pkg::tok_type          tok_in,
   input  khtbl_pkg::wr_type           wr,
   output khtbl_pkg::tok_type          tok_out
);

   logic                           valid_ff;
   logic [khtbl_pkg::KEY_W-1:0]    key_high_ff;
   logic [khtbl_pkg::KEY_W-1:0]    key_low_ff;
   logic [khtbl_pkg::HANDLE_W-1:0] handle_ff;
   khtbl_pkg::tok_type             tok_ff;
   khtbl_pkg::tok_type             tok_in_w;
   logic                           sel;

   assign sel = (wr.kind != khtbl_pkg::WR_NONE) && (wr.idx == cell_idx);

   always_comb begin
      tok_in_w = tok_in;
      // keep the lowest matching slot and the lowest free slot
      if (valid_ff && (key_high_ff == tok_in.key_high) && (key_low_ff == tok_in.key_low)
          && !tok_in.match_hit) begin
         tok_in_w.match_hit    = 1'b1;
         tok_in_w.match_idx    = cell_idx;
         tok_in_w.match_handle = handle_ff;
      end
      if (!valid_ff && !tok_in.free_hit) begin
         tok_in_w.free_hit = 1'b1;
         tok_in_w.free_idx = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff <= tok_in_w;
         if (sel) begin
            case (wr.kind)
               khtbl_pkg::WR_FILL: valid_ff <= 1'b1;
               khtbl_pkg::WR_FREE: valid_ff <= 1'b0;
               default:            valid_ff <= valid_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel && (wr.kind == khtbl_pkg::WR_FILL)) begin
         key_high_ff <= wr.key_high;
         key_low_ff  <= wr.key_low;
      end
      if (sel && ((wr.kind == khtbl_pkg::WR_FILL) || (wr.kind == khtbl_pkg::WR_HANDLE))) begin
         handle_ff <= wr.handle;
      end
   end

   assign tok_out = tok_ff;

endmodule
